[design/pwrf_pkg.sv]
`default_nettype none

package pwrf_pkg;

	// Width of the row number, rank, dense rank and session counters.
	localparam int POSITION_BITS = 32;

	// Value, time and result words.
	localparam int DATA_W = 64;

	// Configuration port: three registers of up to 64 bits at a stride of 8 bytes.
	localparam int ADDR_W = 5;

	// Stream payload widths.
	localparam int S_TDATA_W = 2 * DATA_W;
	localparam int S_TUSER_W = 4;
	localparam int M_TDATA_W = DATA_W;
	localparam int M_TUSER_W = 1;

	// Window function codes.
	typedef enum logic [2:0] {
		FN_ROW_NUMBER = 3'd0,
		FN_RANK       = 3'd1,
		FN_DENSE_RANK = 3'd2,
		FN_SUM        = 3'd3,
		FN_MIN        = 3'd4,
		FN_MAX        = 3'd5,
		FN_DELTA      = 3'd6,
		FN_SESSION    = 3'd7
	} fn_t;

	// Register indexes on the configuration port.
	typedef enum logic [1:0] {
		REG_FUNCTION_SELECT = 2'd0,
		REG_VALUE_UNSIGNED  = 2'd1,
		REG_SESSION_GAP     = 2'd2
	} reg_idx_t;

	typedef logic [POSITION_BITS-1:0] pos_t;
	typedef logic [DATA_W-1:0] data_t;

	localparam pos_t POS_ONE = pos_t'(1);
	localparam pos_t POS_MAX = '1;

	// Saturating increment of a counter.
	function automatic pos_t sat_inc(pos_t v);
		return (v == POS_MAX) ? v : v + POS_ONE;
	endfunction

	// Zero-extends a counter to a result word.
	function automatic data_t pos_to_data(pos_t v);
		return {{(DATA_W-POSITION_BITS){1'b0}}, v};
	endfunction

	// Row held in the input register, with the differences to the previous row
	// already formed.
	typedef struct packed {
		logic              partition_start;
		logic              order_peer;
		data_t             row_value;
		logic              value_is_null;
		logic              time_is_null;
		data_t             value_delta;
		logic              prev_value_null;
		logic [DATA_W:0]   time_delta;
		logic              prev_time_null;
	} row_t;

endpackage

`default_nettype wire

[design/partition_running_window_functions.sv]
`default_nettype none

// Causal window functions over rows that arrive sorted by partition and order
// key. Each accepted row gives exactly one result beat: row number, rank, dense
// rank, running sum (nulls skipped, 64-bit wrap), running min or max (signed or
// unsigned), delta from the previous row, or a session id that steps when the
// time gap exceeds session_gap, as chosen by function_select. One row is taken
// every clock cycle while the output is not stalled. A row's result is formed
// as the row leaves the input register and is then held in the result register
// until the output takes it. At most two rows are in flight, so a stalled
// output holds off the input after two rows. That rate is set by the running
// state, which is read and rewritten as a row leaves the input register. Every
// running quantity is kept on every row, so a new selection applies at once.
// Configuration may be written only while no row is in flight.
module partition_running_window_functions (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// Row stream in.
	input  wire logic                              s_tvalid,
	output      logic                              s_tready,
	// row_value [63:0], row_time [127:64]
	input  wire logic [pwrf_pkg::S_TDATA_W-1:0]    s_tdata,
	// partition_start [0], order_peer [1], value_is_null [2], time_is_null [3]
	input  wire logic [pwrf_pkg::S_TUSER_W-1:0]    s_tuser,
	// Result stream out.
	output      logic                              m_tvalid,
	input  wire logic                              m_tready,
	// result [63:0]
	output      logic [pwrf_pkg::M_TDATA_W-1:0]    m_tdata,
	// result_null [0]
	output      logic [pwrf_pkg::M_TUSER_W-1:0]    m_tuser,
	// Configuration port.
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [pwrf_pkg::ADDR_W-1:0]       paddr,
	input  wire logic [pwrf_pkg::DATA_W-1:0]       pwdata,
	output      logic [pwrf_pkg::DATA_W-1:0]       prdata,
	output      logic                              pready
);
	import pwrf_pkg::*;

	// Configuration registers.
	fn_t      fn_q;
	logic     value_unsigned_q;
	data_t    session_gap_q;
	reg_idx_t reg_idx;
	logic     cfg_write;

	// Input side: the previous accepted row's value and time.
	data_t last_value_q;
	logic  last_value_null_q;
	data_t last_time_q;
	logic  last_time_null_q;

	// Input register.
	row_t  row_s1;
	logic  valid_s1;
	logic  in_beat;
	logic  advance;

	// Running state.
	pos_t  row_position_q;
	pos_t  rank_q;
	pos_t  dense_q;
	data_t sum_q;
	data_t extreme_q;
	logic  extreme_valid_q;
	pos_t  session_q;

	// Next state and result.
	logic  first_row;
	pos_t  row_position_n;
	pos_t  rank_n;
	pos_t  dense_n;
	data_t sum_base;
	data_t sum_n;
	logic  extreme_base_valid;
	logic  [DATA_W-1:0] key_new;
	logic  [DATA_W-1:0] key_old;
	logic  take_extreme;
	data_t extreme_n;
	logic  extreme_valid_n;
	logic  delta_null;
	logic  gap_exceeded;
	pos_t  session_n;
	data_t result_n;
	logic  result_null_n;

	// Result register.
	logic  out_valid_q;
	data_t result_q;
	logic  result_null_q;

	assign pready    = 1'b1;
	assign reg_idx   = reg_idx_t'(paddr[ADDR_W-1:3]);
	assign cfg_write = psel && penable && pwrite && pready;

	// Configuration writes; an unknown index is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fn_q             <= FN_ROW_NUMBER;
			value_unsigned_q <= 1'b0;
			session_gap_q    <= '0;
		end else if (cfg_write) begin
			case (reg_idx)
				REG_FUNCTION_SELECT: fn_q             <= fn_t'(pwdata[2:0]);
				REG_VALUE_UNSIGNED:  value_unsigned_q <= pwdata[0];
				REG_SESSION_GAP:     session_gap_q    <= pwdata;
				default: ;
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		case (reg_idx)
			REG_FUNCTION_SELECT: prdata = {{(DATA_W-3){1'b0}}, fn_q};
			REG_VALUE_UNSIGNED:  prdata = {{(DATA_W-1){1'b0}}, value_unsigned_q};
			REG_SESSION_GAP:     prdata = session_gap_q;
			default:             prdata = '0;
		endcase
	end

	// Handshake: the input register moves on when the result register is free
	// or is being emptied in the same cycle.
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign in_beat  = s_tvalid && s_tready;

	// Previous-row tracking at the input, so that differences are formed early.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_value_null_q <= 1'b1;
			last_time_null_q  <= 1'b1;
		end else if (in_beat) begin
			last_value_null_q <= s_tuser[2];
			last_time_null_q  <= s_tuser[3];
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			last_value_q <= s_tdata[DATA_W-1:0];
			last_time_q  <= s_tdata[2*DATA_W-1:DATA_W];
		end
	end

	// Input register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_beat) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input register payload, with value delta and exact 65-bit time delta.
	always_ff @(posedge clk) begin
		if (in_beat) begin
			row_s1.partition_start <= s_tuser[0];
			row_s1.order_peer      <= s_tuser[1];
			row_s1.row_value       <= s_tdata[DATA_W-1:0];
			row_s1.value_is_null   <= s_tuser[2];
			row_s1.time_is_null    <= s_tuser[3];
			row_s1.value_delta     <= s_tdata[DATA_W-1:0] - last_value_q;
			row_s1.prev_value_null <= last_value_null_q;
			row_s1.time_delta      <= {s_tdata[2*DATA_W-1], s_tdata[2*DATA_W-1:DATA_W]}
				- {last_time_q[DATA_W-1], last_time_q};
			row_s1.prev_time_null  <= last_time_null_q;
		end
	end

	// Counters. A zero row position means no row has been seen since reset.
	always_comb begin
		first_row      = row_s1.partition_start || (row_position_q == '0);
		row_position_n = first_row ? POS_ONE : sat_inc(row_position_q);
		rank_n         = (first_row || !row_s1.order_peer) ? row_position_n : rank_q;
		if (first_row) begin
			dense_n = POS_ONE;
		end else if (!row_s1.order_peer) begin
			dense_n = sat_inc(dense_q);
		end else begin
			dense_n = dense_q;
		end
	end

	// Running sum, nulls skipped.
	always_comb begin
		sum_base = first_row ? '0 : sum_q;
		sum_n    = row_s1.value_is_null ? sum_base : sum_base + row_s1.row_value;
	end

	// Running extreme. Flipping the sign bit turns a signed compare into an
	// unsigned one; ties keep the earlier value.
	always_comb begin
		extreme_base_valid = first_row ? 1'b0 : extreme_valid_q;
		key_new = {row_s1.row_value[DATA_W-1] ^ !value_unsigned_q,
			row_s1.row_value[DATA_W-2:0]};
		key_old = {extreme_q[DATA_W-1] ^ !value_unsigned_q, extreme_q[DATA_W-2:0]};
		take_extreme = !row_s1.value_is_null && (!extreme_base_valid
			|| ((fn_q == FN_MIN) && (key_new < key_old))
			|| ((fn_q == FN_MAX) && (key_new > key_old)));
		extreme_n       = take_extreme ? row_s1.row_value : extreme_q;
		extreme_valid_n = extreme_base_valid || take_extreme;
	end

	// Delta and session id.
	always_comb begin
		delta_null   = first_row || row_s1.value_is_null || row_s1.prev_value_null;
		gap_exceeded = $signed(row_s1.time_delta)
			> $signed({session_gap_q[DATA_W-1], session_gap_q});
		if (first_row) begin
			session_n = POS_ONE;
		end else if (!row_s1.time_is_null && !row_s1.prev_time_null && gap_exceeded) begin
			session_n = sat_inc(session_q);
		end else begin
			session_n = session_q;
		end
	end

	// Result selection.
	always_comb begin
		result_null_n = 1'b0;
		case (fn_q)
			FN_ROW_NUMBER: result_n = pos_to_data(row_position_n);
			FN_RANK:       result_n = pos_to_data(rank_n);
			FN_DENSE_RANK: result_n = pos_to_data(dense_n);
			FN_SUM:        result_n = sum_n;
			FN_MIN, FN_MAX: begin
				result_null_n = !extreme_valid_n;
				result_n      = extreme_valid_n ? extreme_n : '0;
			end
			FN_DELTA: begin
				result_null_n = delta_null;
				result_n      = delta_null ? '0 : row_s1.value_delta;
			end
			FN_SESSION:    result_n = pos_to_data(session_n);
			default:       result_n = '0;
		endcase
	end

	// Running state update as a row leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_position_q  <= '0;
			rank_q          <= '0;
			dense_q         <= '0;
			sum_q           <= '0;
			extreme_q       <= '0;
			extreme_valid_q <= 1'b0;
			session_q       <= '0;
		end else if (advance) begin
			row_position_q  <= row_position_n;
			rank_q          <= rank_n;
			dense_q         <= dense_n;
			sum_q           <= sum_n;
			extreme_q       <= extreme_n;
			extreme_valid_q <= extreme_valid_n;
			session_q       <= session_n;
		end
	end

	// Result register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (advance) begin
			result_q      <= result_n;
			result_null_q <= result_null_n;
		end
	end

	assign m_tvalid   = out_valid_q;
	assign m_tdata    = result_q;
	assign m_tuser[0] = result_null_q;

`ifndef SYNTH
	// A null result carries a zero word.
	a_null_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && result_null_q) |-> (result_q == '0))
		else $error("null result with nonzero data");

	// Once a row has passed, the row position never returns to zero.
	a_position_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (row_position_q != '0))
		else $error("row position zero after a row");

	// Dense rank never exceeds rank, and rank never exceeds the row number.
	a_rank_order: assert property (@(posedge clk) disable iff (!arst_n)
		(dense_q <= rank_q) && (rank_q <= row_position_q))
		else $error("rank counters out of order");

	// An empty input register always takes a beat.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_tready)
		else $error("input stalled with empty input register");
`endif

endmodule

`default_nettype wire

[tb/window_fn_checker.sv]
`timescale 1ns / 1ps

// Watches the row and result streams and the register port of the window
// function block. It keeps its own copy of the registers and of the running
// state, predicts one result per accepted row and compares every result beat
// with the oldest prediction.
module window_fn_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [pwrf_pkg::S_TDATA_W-1:0] s_tdata,
	input  logic [pwrf_pkg::S_TUSER_W-1:0] s_tuser,
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [pwrf_pkg::M_TDATA_W-1:0] m_tdata,
	input  logic [pwrf_pkg::M_TUSER_W-1:0] m_tuser,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [pwrf_pkg::ADDR_W-1:0]    paddr,
	input  logic [pwrf_pkg::DATA_W-1:0]    pwdata,
	input  logic                           pready,
	output int                             fail_count,
	output int                             rows_pending,
	output int                             results_checked
);
	import pwrf_pkg::*;

	localparam int REPORT_LIMIT = 10;
	localparam data_t SIGN_BIT = {1'b1, {(DATA_W-1){1'b0}}};

	typedef struct packed {
		data_t value;
		logic  is_null;
	} window_out_t;

	// Copies of the configuration registers.
	fn_t   fn_sel;
	logic  cmp_unsigned;
	data_t gap_limit;

	// Running state, kept on every row whatever function is selected.
	pos_t  row_pos;
	pos_t  rank_cnt;
	pos_t  dense_cnt;
	pos_t  session_cnt;
	data_t run_sum;
	data_t extreme;
	logic  extreme_seen;
	data_t prev_value;
	logic  prev_value_null;
	data_t prev_time;
	logic  prev_time_null;

	// Results predicted for rows that went in, oldest first.
	window_out_t results_due[$];
	int errors = 0;
	int checked = 0;

	// Counters stop at their largest value instead of wrapping.
	function automatic pos_t count_up(input pos_t v);
		return (v == '1) ? v : v + pos_t'(1);
	endfunction

	function automatic void flag_error(input string msg);
		errors++;
		if (errors <= REPORT_LIMIT)
			$display("%s", msg);
	endfunction

	// Advances the running state by one row and returns the selected result.
	function automatic window_out_t window_row(input logic part_start, input logic peer,
			input data_t val, input logic val_null, input data_t tstamp,
			input logic tstamp_null);
		logic               opens;
		logic               take;
		logic               delta_null;
		data_t              flip;
		data_t              delta;
		logic signed [65:0] t_ext;
		logic signed [65:0] p_ext;
		logic signed [65:0] g_ext;
		window_out_t        r;

		// A row opens a partition on its flag, or when no row came before.
		opens = part_start || (row_pos == '0);
		row_pos = opens ? pos_t'(1) : count_up(row_pos);

		if (opens || !peer)
			rank_cnt = row_pos;
		if (opens)
			dense_cnt = pos_t'(1);
		else if (!peer)
			dense_cnt = count_up(dense_cnt);

		// Nulls are skipped; the sum wraps at 64 bits.
		if (opens)
			run_sum = '0;
		if (!val_null)
			run_sum = run_sum + val;

		// Flipping the sign bit turns a signed compare into an unsigned one.
		if (opens)
			extreme_seen = 1'b0;
		if (!val_null) begin
			flip = cmp_unsigned ? '0 : SIGN_BIT;
			take = !extreme_seen ||
				(fn_sel == FN_MIN && (val ^ flip) < (extreme ^ flip)) ||
				(fn_sel == FN_MAX && (val ^ flip) > (extreme ^ flip));
			if (take) begin
				extreme = val;
				extreme_seen = 1'b1;
			end
		end

		delta_null = opens || val_null || prev_value_null;
		delta = val - prev_value;
		prev_value = val;
		prev_value_null = val_null;

		// The gap test uses the exact difference, so it needs more than 64 bits.
		if (opens) begin
			session_cnt = pos_t'(1);
		end else if (!tstamp_null && !prev_time_null) begin
			t_ext = $signed(tstamp);
			p_ext = $signed(prev_time);
			g_ext = $signed(gap_limit);
			if (t_ext - p_ext - g_ext > 0)
				session_cnt = count_up(session_cnt);
		end
		prev_time = tstamp;
		prev_time_null = tstamp_null;

		r.is_null = 1'b0;
		case (fn_sel)
			FN_ROW_NUMBER: r.value = data_t'(row_pos);
			FN_RANK:       r.value = data_t'(rank_cnt);
			FN_DENSE_RANK: r.value = data_t'(dense_cnt);
			FN_SUM:        r.value = run_sum;
			FN_MIN, FN_MAX: begin
				r.is_null = !extreme_seen;
				r.value = extreme_seen ? extreme : '0;
			end
			FN_DELTA: begin
				r.is_null = delta_null;
				r.value = delta_null ? '0 : delta;
			end
			default:       r.value = data_t'(session_cnt);
		endcase
		return r;
	endfunction

	// Follows register writes, predicts on row beats and checks result beats.
	always @(posedge clk or negedge arst_n) begin
		window_out_t want;
		window_out_t got_row;
		if (!arst_n) begin
			fn_sel = FN_ROW_NUMBER;
			cmp_unsigned = 1'b0;
			gap_limit = '0;
			row_pos = '0;
			rank_cnt = '0;
			dense_cnt = '0;
			session_cnt = '0;
			run_sum = '0;
			extreme = '0;
			extreme_seen = 1'b0;
			prev_value = '0;
			prev_value_null = 1'b1;
			prev_time = '0;
			prev_time_null = 1'b1;
			results_due.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[ADDR_W-1:3]))
					REG_FUNCTION_SELECT: fn_sel = fn_t'(pwdata[2:0]);
					REG_VALUE_UNSIGNED:  cmp_unsigned = pwdata[0];
					REG_SESSION_GAP:     gap_limit = pwdata;
					default: ;
				endcase
			end

			if (s_tvalid && s_tready) begin
				got_row = window_row(s_tuser[0], s_tuser[1],
					s_tdata[DATA_W-1:0], s_tuser[2], s_tdata[2*DATA_W-1:DATA_W],
					s_tuser[3]);
				results_due.insert(results_due.size(), got_row);
			end

			if (m_tvalid && m_tready) begin
				if (results_due.size() == 0) begin
					flag_error($sformatf(
						"result beat %h null %b arrived with no row pending",
						m_tdata, m_tuser[0]));
				end else begin
					want = results_due[0];
					results_due.delete(0);
					if (m_tdata !== want.value || m_tuser[0] !== want.is_null)
						flag_error($sformatf(
							"result %0d: expected %h null %b, got %h null %b",
							checked, want.value, want.is_null, m_tdata, m_tuser[0]));
					checked++;
				end
			end
		end
		fail_count <= errors;
		rows_pending <= results_due.size();
		results_checked <= checked;
	end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

// Drives rows and register writes into the window function block, with the
// checker beside it, and gives the verdict.
module tb;
	import pwrf_pkg::*;

	localparam int PHASES = 12;
	localparam int ROWS_PER_PHASE = 110;
	localparam int HOLD_CYCLES = 200;
	localparam int DRAIN_CYCLES = 10;
	localparam int CYCLE_LIMIT = 300000;
	localparam logic [1:0] REG_SPARE = 2'd3;
	localparam data_t S64_MAX = {1'b0, {63{1'b1}}};
	localparam data_t S64_MIN = {1'b1, {63{1'b0}}};

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	// row_value [63:0], row_time [127:64]
	logic [S_TDATA_W-1:0] s_tdata;
	// partition_start [0], order_peer [1], value_is_null [2], time_is_null [3]
	logic [S_TUSER_W-1:0] s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	// result [63:0]
	logic [M_TDATA_W-1:0] m_tdata;
	// result_null [0]
	logic [M_TUSER_W-1:0] m_tuser;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [ADDR_W-1:0]    paddr;
	logic [DATA_W-1:0]    pwdata;
	logic [DATA_W-1:0]    prdata;
	logic                 pready;

	int fail_count;
	int rows_pending;
	int results_checked;
	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	int rows_sent = 0;
	int cycles = 0;
	bit hold_req = 1'b0;

	partition_running_window_functions u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	window_fn_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tuser         (s_tuser),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.m_tuser         (m_tuser),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.pready          (pready),
		.fail_count      (fail_count),
		.rows_pending    (rows_pending),
		.results_checked (results_checked)
	);

	// Clock with a 10 ns period.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Guards against a hung handshake.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still pending", cycles,
				rows_pending);
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Result side: random stalls, and one long hold-off on request.
	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				for (int n = 0; n < HOLD_CYCLES; n++)
					@(posedge clk);
				hold_req = 1'b0;
			end
			m_tready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// Offers one row beat, after random idle cycles, and waits until it is taken.
	task automatic send_row(input logic part_start, input logic peer, input data_t val,
			input logic val_null, input data_t tstamp, input logic tstamp_null);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {tstamp, val};
		s_tuser <= {tstamp_null, val_null, peer, part_start};
		do @(posedge clk); while (!s_tready);
		rows_sent++;
	endtask

	// Register write: setup, then access until ready, then idle.
	task automatic write_reg(input logic [1:0] idx, input data_t val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// Lets every outstanding result come out before registers change.
	task automatic wait_results_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (rows_pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		fn_t   fn;
		logic  use_unsigned;
		data_t gap;
		data_t noise;
		data_t val;
		data_t tstamp;
		logic  part_start;
		logic  peer;
		logic  val_null;
		logic  tstamp_null;

		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		tstamp = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Rank: the very first row opens a partition without its flag, and the
		// peer flag is ignored on the first row of any partition.
		write_reg(REG_FUNCTION_SELECT, data_t'(FN_RANK));
		send_row(1'b0, 1'b1, data_t'(10), 1'b0, data_t'(0), 1'b0);
		send_row(1'b0, 1'b1, data_t'(11), 1'b0, data_t'(1), 1'b0);
		send_row(1'b0, 1'b0, data_t'(12), 1'b0, data_t'(2), 1'b0);
		send_row(1'b0, 1'b1, data_t'(13), 1'b0, data_t'(3), 1'b0);
		send_row(1'b1, 1'b1, data_t'(14), 1'b0, data_t'(4), 1'b0);

		// Sum wraps at 64 bits and skips nulls; a write to an unused index is ignored.
		wait_results_drained();
		write_reg(REG_SPARE, '1);
		write_reg(REG_FUNCTION_SELECT, data_t'(FN_SUM));
		send_row(1'b1, 1'b0, S64_MAX, 1'b0, data_t'(5), 1'b0);
		send_row(1'b0, 1'b0, data_t'(1), 1'b0, data_t'(6), 1'b0);
		send_row(1'b0, 1'b0, '1, 1'b1, data_t'(7), 1'b0);
		send_row(1'b0, 1'b0, S64_MIN, 1'b0, data_t'(8), 1'b0);

		// Signed minimum: null until a value arrives, extremes of the value range.
		wait_results_drained();
		write_reg(REG_FUNCTION_SELECT, data_t'(FN_MIN));
		write_reg(REG_VALUE_UNSIGNED, data_t'(0));
		send_row(1'b1, 1'b0, data_t'(5), 1'b1, data_t'(9), 1'b0);
		send_row(1'b0, 1'b0, '1, 1'b0, data_t'(10), 1'b0);
		send_row(1'b0, 1'b0, S64_MAX, 1'b0, data_t'(11), 1'b0);
		send_row(1'b0, 1'b0, S64_MIN, 1'b0, data_t'(12), 1'b0);

		// Unsigned maximum: all ones stays above the largest signed value.
		wait_results_drained();
		write_reg(REG_FUNCTION_SELECT, data_t'(FN_MAX));
		write_reg(REG_VALUE_UNSIGNED, data_t'(1));
		send_row(1'b1, 1'b0, '1, 1'b0, data_t'(13), 1'b0);
		send_row(1'b0, 1'b0, S64_MAX, 1'b0, data_t'(14), 1'b0);

		// Delta: null on a partition's first row and around null values.
		wait_results_drained();
		write_reg(REG_FUNCTION_SELECT, data_t'(FN_DELTA));
		send_row(1'b1, 1'b0, data_t'(7), 1'b0, data_t'(15), 1'b0);
		send_row(1'b0, 1'b0, S64_MIN, 1'b0, data_t'(16), 1'b0);
		send_row(1'b0, 1'b0, data_t'(3), 1'b1, data_t'(17), 1'b0);
		send_row(1'b0, 1'b0, S64_MAX, 1'b0, data_t'(18), 1'b0);

		// Session with the largest gap: only the full 65-bit span exceeds it.
		wait_results_drained();
		write_reg(REG_FUNCTION_SELECT, data_t'(FN_SESSION));
		write_reg(REG_SESSION_GAP, S64_MAX);
		send_row(1'b1, 1'b0, '0, 1'b0, S64_MIN, 1'b0);
		send_row(1'b0, 1'b0, '0, 1'b0, S64_MAX, 1'b0);
		send_row(1'b0, 1'b0, '0, 1'b0, '0, 1'b1);
		send_row(1'b0, 1'b0, '0, 1'b0, '0, 1'b0);

		// Session with the most negative gap: a full backward span does not exceed it.
		wait_results_drained();
		write_reg(REG_SESSION_GAP, S64_MIN);
		send_row(1'b1, 1'b0, '0, 1'b0, S64_MAX, 1'b0);
		send_row(1'b0, 1'b0, '0, 1'b0, S64_MIN, 1'b0);
		send_row(1'b0, 1'b0, '0, 1'b0, S64_MIN, 1'b0);

		// Random phases: each selects a function and a pacing mix.
		for (int p = 0; p < PHASES; p++) begin
			wait_results_drained();
			if (p < 8)
				fn = fn_t'(p[2:0]);
			else if (p == 8)
				fn = FN_MIN;
			else if (p == 9)
				fn = FN_MAX;
			else
				fn = FN_SESSION;
			use_unsigned = p[0] ^ (p >= 8);
			if (p == 10)
				gap = data_t'(0) - data_t'($urandom_range(5));
			else if (p == 11)
				gap = {$urandom, $urandom};
			else
				gap = data_t'($urandom_range(30));

			// Upper bits of the narrow registers carry noise.
			noise = {$urandom, $urandom};
			write_reg(REG_FUNCTION_SELECT, {noise[63:3], fn});
			write_reg(REG_VALUE_UNSIGNED, {noise[63:1], use_unsigned});
			write_reg(REG_SESSION_GAP, gap);

			case (p % 4)
				0: begin
					src_idle_pct = 0;
					sink_stall_pct = 0;
				end
				1: begin
					src_idle_pct = 64;
					sink_stall_pct = 0;
				end
				2: begin
					src_idle_pct = 0;
					sink_stall_pct = 64;
				end
				default: begin
					src_idle_pct = 29;
					sink_stall_pct = 29;
				end
			endcase
			// The first phase backs up the result side while rows keep coming.
			if (p == 0)
				hold_req = 1'b1;

			for (int i = 0; i < ROWS_PER_PHASE; i++) begin
				part_start = ($urandom_range(11) == 0);
				peer = ($urandom_range(9) < 4);
				val_null = ($urandom_range(9) == 0);
				tstamp_null = ($urandom_range(11) == 0);
				case ($urandom_range(9))
					0: val = {$urandom, $urandom};
					1: begin
						case ($urandom_range(3))
							0: val = S64_MAX;
							1: val = S64_MIN;
							2: val = '0;
							default: val = '1;
						endcase
					end
					default: val = data_t'($urandom_range(2000)) - data_t'(1000);
				endcase
				// Times mostly creep forward, sometimes step back or jump anywhere.
				case ($urandom_range(19))
					0: tstamp = {$urandom, $urandom};
					1: tstamp = tstamp - data_t'($urandom_range(40));
					default: tstamp = tstamp + data_t'($urandom_range(40));
				endcase
				send_row(part_start, peer, val, val_null, tstamp, tstamp_null);
			end
		end

		wait_results_drained();
		$display("%0d rows sent, %0d results compared, %0d random phases.",
			rows_sent, results_checked, PHASES);
		$display("All functions, both compare modes, extreme gaps and a long output hold.");
		if (fail_count == 0 && rows_pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
